@@ src/rlrd_pkg.sv @@
// Package for the radar line run-length decoder.
// Holds the command, state and code-class types and the code byte constants.
// Depends on nothing.
package rlrd_pkg;

	// Command carried by one input beat.
	typedef enum logic [1:0] {
		CMD_LINE_START = 2'd0,
		CMD_CODE       = 2'd1,
		CMD_LINE_END   = 2'd2,
		CMD_READ       = 2'd3
	} cmd_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_READ
	} state_t;

	// What a code byte does when no run count is awaited.
	typedef enum logic [1:0] {
		CC_SKIP,
		CC_INC,
		CC_RUN,
		CC_LIT
	} code_class_t;

	// Kind of a result beat.
	localparam logic RK_PIXEL = 1'b0;
	localparam logic RK_LINE  = 1'b1;

	// Special code bytes.
	localparam logic [7:0] CODE_SKIP  = 8'h01;
	localparam logic [7:0] CODE_INC_A = 8'h54;
	localparam logic [7:0] CODE_INC_B = 8'hA9;
	localparam logic [7:0] CODE_INC_C = 8'hFE;
	localparam logic [7:0] CODE_RUN_A = 8'h00;
	localparam logic [7:0] CODE_RUN_B = 8'h55;
	localparam logic [7:0] CODE_RUN_C = 8'hAA;
	localparam logic [7:0] CODE_RUN_D = 8'hFF;

	// Classify a code byte.
	function automatic code_class_t code_class(input logic [7:0] b);
		code_class_t c;
		c = CC_LIT;
		if (b == CODE_SKIP) begin
			c = CC_SKIP;
		end else if (b == CODE_INC_A || b == CODE_INC_B || b == CODE_INC_C) begin
			c = CC_INC;
		end else if (b == CODE_RUN_A || b == CODE_RUN_B || b == CODE_RUN_C ||
			b == CODE_RUN_D) begin
			c = CC_RUN;
		end
		return c;
	endfunction

endpackage

@@ src/radar_line_rle_decoder.sv @@
// Top level of the radar line run-length decoder: controller and image store.
// Depends on rlrd_pkg for the command, state and code-class types.
//
//  Channel  | Handshake             | Fields
//  ---------+-----------------------+------------------------------------------------
//  input    | start, busy           | cmd, line_number, code_byte, point_index
//  result   | result_valid (strobe) | result_kind, pixel_value, updated_line, overflow
//
// After reset the whole store is cleared one byte a cycle, with busy high throughout.
// Line start, line end and plain code beats leave busy low; a line-end result
// appears in the cycle after its beat. A pixel read holds busy high in ST_READ
// while the store output is registered in rd_data_q, and its result beat is
// registered from that value. A run count of n holds busy high in ST_FILL while
// the fill covers n points, one point a cycle, through the single store write
// port. The receiver cannot stall results.
module radar_line_rle_decoder #(
	parameter int LINE_COUNT      = 1024,
	parameter int POINTS_PER_LINE = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rlrd_pkg::cmd_t     cmd,
	input  logic [15:0]        line_number,
	input  logic [7:0]         code_byte,
	input  logic [8:0]         point_index,
	output logic               result_valid,
	output logic               result_kind,
	output logic [7:0]         pixel_value,
	output logic [9:0]         updated_line,
	output logic               overflow
);
	import rlrd_pkg::*;

	localparam int LW    = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
	localparam int PW    = $clog2(POINTS_PER_LINE);
	localparam int AW    = LW + PW;
	localparam int DEPTH = LINE_COUNT * (2 ** PW);
	localparam int XW    = (PW > 9) ? PW : 9;

	localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
	localparam logic [PW:0]   POINTS_END = (PW + 1)'(POINTS_PER_LINE);

	// Image store: one byte per point, rows padded to a power of two.
	logic [7:0] mem [DEPTH];

	state_t       state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [15:0]  active_line_q;
	logic         line_ok_q;
	logic [PW:0]  wpos_q;
	logic         run_pending_q;
	logic [7:0]   run_level_q;
	logic         clipped_q;
	logic [7:0]   fill_cnt_q;
	logic [7:0]   rd_data_q;
	logic         rd_oob_q;
	logic         result_valid_q;
	logic         result_kind_q;
	logic [7:0]   pixel_value_q;
	logic [9:0]   updated_line_q;
	logic         overflow_q;

	logic         accept;
	logic         put_go;
	logic [7:0]   put_val;
	logic         pos_in_line;
	logic         mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]   mem_wdata;
	logic         rd_oob;
	logic [XW-1:0] pt_ext;
	logic [AW-1:0] rd_addr;
	code_class_t  cclass;

	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && (state_q == ST_IDLE);
	assign pos_in_line  = (wpos_q < POINTS_END);
	assign cclass       = code_class(code_byte);

	// Pixel read address and range check.
	assign pt_ext  = XW'(point_index);
	assign rd_oob  = !((32'(line_number) < LINE_COUNT) &&
		(32'(point_index) < POINTS_PER_LINE));
	assign rd_addr = {line_number[LW-1:0], pt_ext[PW-1:0]};

	// Next state and the store write port.
	always_comb begin
		state_d   = state_q;
		put_go    = 1'b0;
		put_val   = code_byte;
		mem_we    = 1'b0;
		mem_waddr = {active_line_q[LW-1:0], wpos_q[PW-1:0]};
		mem_wdata = put_val;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_CODE: begin
							if (run_pending_q) begin
								if (code_byte != 8'd0) begin
									state_d = ST_FILL;
								end
							end else if (cclass == CC_INC) begin
								put_go  = 1'b1;
								put_val = code_byte + 8'd1;
							end else if (cclass == CC_LIT) begin
								put_go = 1'b1;
							end
						end
						CMD_READ: begin
							state_d = ST_READ;
						end
						default: begin
						end
					endcase
				end
			end
			ST_FILL: begin
				put_go  = 1'b1;
				put_val = run_level_q;
				if (fill_cnt_q == 8'd1) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = 8'd0;
		end else begin
			mem_wdata = put_val;
			mem_we    = put_go && pos_in_line && line_ok_q;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Store write and pixel read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept && cmd == CMD_READ && !rd_oob) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Line decoding state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q         <= '0;
			active_line_q <= '0;
			line_ok_q     <= 1'b0;
			wpos_q        <= '0;
			run_pending_q <= 1'b0;
			run_level_q   <= '0;
			clipped_q     <= 1'b0;
			fill_cnt_q    <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (put_go) begin
				if (pos_in_line) begin
					wpos_q <= wpos_q + 1'b1;
				end else begin
					clipped_q <= 1'b1;
				end
			end
			if (state_q == ST_FILL) begin
				fill_cnt_q <= fill_cnt_q - 8'd1;
			end
			if (accept) begin
				case (cmd)
					CMD_LINE_START: begin
						active_line_q <= line_number;
						line_ok_q     <= (32'(line_number) < LINE_COUNT);
						wpos_q        <= '0;
						run_pending_q <= 1'b0;
						run_level_q   <= '0;
						clipped_q     <= 1'b0;
					end
					CMD_CODE: begin
						if (run_pending_q) begin
							run_pending_q <= 1'b0;
							fill_cnt_q    <= code_byte;
						end else if (cclass == CC_SKIP) begin
							if (pos_in_line) begin
								wpos_q <= wpos_q + 1'b1;
							end
						end else if (cclass == CC_RUN) begin
							run_pending_q <= 1'b1;
							run_level_q   <= code_byte;
						end
					end
					CMD_LINE_END: begin
						if (run_pending_q) begin
							run_pending_q <= 1'b0;
							clipped_q     <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (accept && cmd == CMD_LINE_END) || (state_q == ST_READ);
		end
	end

	// Result beat payload.
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_READ) begin
			rd_oob_q <= rd_oob;
		end
		if (accept && cmd == CMD_LINE_END) begin
			result_kind_q  <= RK_LINE;
			pixel_value_q  <= 8'd0;
			updated_line_q <= active_line_q[9:0];
			overflow_q     <= !line_ok_q || clipped_q || run_pending_q;
		end else if (state_q == ST_READ) begin
			result_kind_q  <= RK_PIXEL;
			pixel_value_q  <= rd_oob_q ? 8'd0 : rd_data_q;
			updated_line_q <= 10'd0;
			overflow_q     <= rd_oob_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result_kind  = result_kind_q;
	assign pixel_value  = pixel_value_q;
	assign updated_line = updated_line_q;
	assign overflow     = overflow_q;

endmodule
